>>> hdl/superio_config_register_decoder_unit_defines.svh
// Assertion macros for the super I/O config register decoder.
// Used by the top level; no other dependencies.
`ifndef SUPERIO_CONFIG_REGISTER_DECODER_UNIT_DEFINES_SVH
`define SUPERIO_CONFIG_REGISTER_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SCRD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("scrd assertion failed");
`define SCRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scrd assertion failed");
`else
`define SCRD_ASSERT(lbl, clk, rstn, prop)
`define SCRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/scrd_pkg.sv
// Shared types, constants and decode functions for the config register decoder.
// No dependencies.
package scrd_pkg;

  localparam int NUM_REGS_DEF = 28;

  localparam int DATA_W = 8;
  localparam int BASE_W = 10;

  // access kinds and port selects
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // register numbers with a decoded meaning
  localparam logic [DATA_W-1:0] REG_FLOPPY = 8'd0;
  localparam logic [DATA_W-1:0] REG_PORTS  = 8'd1;
  localparam logic [DATA_W-1:0] REG_MISC   = 8'd9;
  localparam logic [DATA_W-1:0] REG_MISC_RST = 8'hFF;
  localparam int POL_BIT = 6;

  localparam logic [1:0] PAR_OFF = 2'd3;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } ctrl_state_e;

  typedef struct packed {
    logic take;  // accept the item, update state, load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic              density_polarity;
    logic [BASE_W-1:0] uart2_base;
    logic [BASE_W-1:0] uart1_base;
    logic [BASE_W-1:0] parallel_base;
    logic              parallel_enable;
    logic [BASE_W-1:0] floppy_base;
    logic              floppy_enable;
    logic [DATA_W-1:0] read_data;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  function automatic logic [BASE_W-1:0] floppy_base_f(input logic alt);
    return alt ? 10'h370 : 10'h3F0;
  endfunction

  function automatic logic [BASE_W-1:0] parallel_base_f(input logic [1:0] sel);
    logic [BASE_W-1:0] b;
    case (sel)
      2'd0:    b = 10'h378;
      2'd1:    b = 10'h3BC;
      2'd2:    b = 10'h278;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [BASE_W-1:0] serial_base_f(input logic [1:0] code,
                                                      input logic [1:0] hi);
    logic [BASE_W-1:0] b;
    case (code)
      2'd0: b = 10'h3F8;
      2'd1: b = 10'h2F8;
      2'd2: begin
        case (hi)
          2'd0:    b = 10'h3E8;
          2'd1:    b = 10'h338;
          2'd2:    b = 10'h2E8;
          default: b = 10'h220;
        endcase
      end
      default: begin
        case (hi)
          2'd0:    b = 10'h2E8;
          2'd1:    b = 10'h238;
          2'd2:    b = 10'h2E0;
          default: b = 10'h228;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

>>> hdl/scrd_ctrl.sv
// Handshake controller for the config register decoder.
// Depends on scrd_pkg.
module scrd_ctrl
  import scrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_o = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_EMPTY: begin
        in_ready_o = 1'b1;
      end
      ST_FULL: begin
        out_valid_o = 1'b1;
        // output register frees up this cycle when the result is taken
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    cmd_o.take = in_valid_i && in_ready_o;
    if (cmd_o.take) begin
      state_d = ST_FULL;
    end else if (out_ready_i) begin
      state_d = ST_EMPTY;
    end
  end

endmodule

>>> hdl/scrd_datapath.sv
// Index/data register file, arm flag, resource decode and output register.
// Depends on scrd_pkg.
module scrd_datapath
  import scrd_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  input  logic              mode_i,
  input  logic              port_sel_i,
  input  logic [DATA_W-1:0] write_data_i,
  output result_t           result_o
);

  localparam int IdxW = $clog2(NUM_REGS);
  localparam logic [IdxW-1:0] FloppyIdx = IdxW'(REG_FLOPPY);
  localparam logic [IdxW-1:0] PortsIdx  = IdxW'(REG_PORTS);

  logic [DATA_W-1:0] index_q, index_d;
  logic              armed_q, armed_d;
  logic              pol_q, pol_d;
  logic [DATA_W-1:0] regs_q [NUM_REGS];
  logic [DATA_W-1:0] regs_d [NUM_REGS];
  result_t           out_q, out_d;

  logic            in_range;
  logic [IdxW-1:0] idx;
  logic            store;
  logic [DATA_W-1:0] rd;

  assign in_range = index_q < DATA_W'(NUM_REGS);
  assign idx      = index_q[IdxW-1:0];
  assign store    = cmd_i.take && (mode_i == MODE_WRITE) && (port_sel_i == PORT_DATA)
                    && armed_q && in_range;

  always_comb begin
    index_d = index_q;
    armed_d = armed_q;
    pol_d   = pol_q;
    regs_d  = regs_q;
    if (cmd_i.take && (mode_i == MODE_WRITE)) begin
      if (port_sel_i == PORT_INDEX) begin
        index_d = write_data_i;
        armed_d = 1'b0;
      end else begin
        // data writes come in pairs: first arms, second stores
        armed_d = !armed_q;
      end
    end
    if (store) begin
      regs_d[idx] = write_data_i;
      if (index_q == REG_MISC) begin
        pol_d = write_data_i[POL_BIT];
      end
    end
  end

  always_comb begin
    rd = '0;
    if (mode_i == MODE_READ) begin
      if (port_sel_i == PORT_INDEX) begin
        rd = index_q;
      end else if (in_range) begin
        rd = regs_q[idx];
      end else begin
        rd = 8'hFF;
      end
    end
  end

  // decode from the register contents as they stand after this access
  always_comb begin
    out_d.read_data        = rd;
    out_d.floppy_enable    = regs_d[FloppyIdx][3];
    out_d.floppy_base      = floppy_base_f(regs_d[FloppyIdx][5]);
    out_d.parallel_enable  = regs_d[PortsIdx][1:0] != PAR_OFF;
    out_d.parallel_base    = parallel_base_f(regs_d[PortsIdx][1:0]);
    out_d.uart1_base       = serial_base_f(regs_d[PortsIdx][3:2], regs_d[PortsIdx][7:6]);
    out_d.uart2_base       = serial_base_f(regs_d[PortsIdx][5:4], regs_d[PortsIdx][7:6]);
    out_d.density_polarity = pol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
      armed_q <= 1'b0;
      pol_q   <= 1'b1;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= (i == int'(REG_MISC)) ? REG_MISC_RST : '0;
      end
    end else begin
      index_q <= index_d;
      armed_q <= armed_d;
      pol_q   <= pol_d;
      regs_q  <= regs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      out_q <= out_d;
    end
  end

  assign result_o = out_q;

endmodule

>>> hdl/superio_config_register_decoder_unit.sv
// Super I/O index/data configuration register decoder. Each accepted bus
// access (read or write, index port or data port) yields exactly one
// transaction on the output: the read byte (zero for writes) and the decoded
// floppy, parallel and serial base addresses plus density polarity as they
// stand after the access. Data port writes store only on the second write in
// a row; an index write disarms. The single output register holds the result,
// valid the cycle after; one access per cycle while m_axis_tready is high.
// Depends on scrd_pkg, scrd_ctrl, scrd_datapath and the defines header.
`include "superio_config_register_decoder_unit_defines.svh"

module superio_config_register_decoder_unit
  import scrd_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [7:0] write_data
  input  logic [1:0]             s_axis_tuser,   // [0] mode, [1] port_sel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] read_data, [8] floppy_enable, [18:9] floppy_base, [19] parallel_enable,
  // [29:20] parallel_base, [39:30] uart1_base, [49:40] uart2_base,
  // [50] density_polarity, [55:51] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ctrl_cmd_t cmd;
  result_t   result;
  logic      in_fire;
  logic      wr_fire;

  scrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  scrd_datapath #(
    .NUM_REGS (NUM_REGS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (s_axis_tuser[0]),
    .port_sel_i   (s_axis_tuser[1]),
    .write_data_i (s_axis_tdata),
    .result_o     (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(result);

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign wr_fire = in_fire && (s_axis_tuser[0] == MODE_WRITE);

  `SCRD_ASSERT(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `SCRD_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_fire, m_axis_tvalid)
  `SCRD_ASSERT_NEXT(a_write_reads_zero, clk_i, rst_ni, wr_fire, m_axis_tdata[DATA_W-1:0] == '0)

endmodule
